@@ hw/rtl/tpq_pkg.sv @@
// Shared types and constants for the timed output pattern queue.
package tpq_pkg;

	// Request kinds
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_ENQ  = 1'b1;

	// Fixed field widths
	localparam int unsigned DATA_W = 32;
	localparam int unsigned FILL_W = 11;

	// One queued operation as held in the store
	typedef struct packed {
		logic [DATA_W-1:0] dur;
		logic [DATA_W-1:0] pat;
	} tpq_op_t;

	localparam int unsigned OP_W = $bits(tpq_op_t);

endpackage

@@ hw/rtl/tpq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tpq_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/timed_output_pattern_queue.sv @@
// Timed output pattern queue: FIFO of (duration, mask) operations stepped by tick requests.
// A request passes the input register and then the result register, which drives its result strobe (done).
// Throughput: one request per cycle; busy is never raised, the queue store is one RAM
// read port plus a prefetched second-entry register, so back-to-back ops need no stall.
// Reset (arst_n low) clears pointers, count, tick counter and output mask; the
// operation store is not cleared and is only ever read where it has been written.
// The receiver cannot stall: every result is shown for exactly one cycle.
module timed_output_pattern_queue
	import tpq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              kind,
	input  logic [DATA_W-1:0] duration,
	input  logic [DATA_W-1:0] pattern,
	output logic              done,
	output logic              accepted,
	output logic              overflow,
	output logic              op_finished,
	output logic [DATA_W-1:0] output_bits,
	output logic              busy_res,
	output logic [FILL_W-1:0] fill_level
);

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	// pointer advance with wrap at the queue depth
	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		r = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
		return r;
	endfunction

	// input stage
	logic              valid_s1;
	logic              kind_s1;
	logic [DATA_W-1:0] dur_s1;
	logic [DATA_W-1:0] pat_s1;

	// queue state
	logic [AW-1:0]     wp_q, rp_q;
	logic [CW-1:0]     cnt_q;
	logic [DATA_W-1:0] tick_q, out_q, hd_dur_q;
	logic [DATA_W-1:0] sec_dur_q, sec_pat_q;
	logic              sec_ram_q;

	// next-state values
	logic [AW-1:0]     wp_n, rp_n, rp1, rp2;
	logic [CW-1:0]     cnt_n;
	logic [DATA_W-1:0] tick_n, out_n, hd_dur_n, tick_inc;
	logic [DATA_W-1:0] sec_dur_n, sec_pat_n, eff_dur, eff_pat;
	logic              sec_ram_n;
	logic              acc_c, ovf_c, fin_c;

	// RAM side
	logic              ram_we, ram_re;
	tpq_op_t           ram_wop, rd_op;
	logic [OP_W-1:0]   rd_word;

	// result stage
	logic              valid_s2, acc_s2, ovf_s2, fin_s2;
	logic [CW-1:0]     cnt_s2;
	logic [DATA_W-1:0] out_s2;

	logic [FILL_W+CW-1:0] fill_ext;

	assign busy = 1'b0;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_s1 <= kind;
			dur_s1  <= duration;
			pat_s1  <= pattern;
		end
	end

	tpq_ram #(
		.WIDTH(OP_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wp_q),
		.wdata(ram_wop),
		.re   (ram_re),
		.raddr(rp2),
		.rdata(rd_word)
	);

	assign rd_op   = tpq_op_t'(rd_word);
	assign ram_wop = '{dur: dur_s1, pat: pat_s1};
	assign rp1     = ptr_inc(rp_q);
	assign rp2     = ptr_inc(rp1);

	// queue update for the request in the input stage
	always_comb begin
		// second entry comes from the RAM in the cycle after its read
		eff_dur   = sec_ram_q ? rd_op.dur : sec_dur_q;
		eff_pat   = sec_ram_q ? rd_op.pat : sec_pat_q;
		tick_inc  = tick_q + DATA_W'(1);
		wp_n      = wp_q;
		rp_n      = rp_q;
		cnt_n     = cnt_q;
		tick_n    = tick_q;
		out_n     = out_q;
		hd_dur_n  = hd_dur_q;
		sec_dur_n = eff_dur;
		sec_pat_n = eff_pat;
		sec_ram_n = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		acc_c     = 1'b0;
		ovf_c     = 1'b0;
		fin_c     = 1'b0;
		if (valid_s1) begin
			if (kind_s1 == KIND_ENQ) begin
				if (cnt_q >= CW'(QUEUE_DEPTH)) begin
					ovf_c = 1'b1;
				end else begin
					ram_we = 1'b1;
					acc_c  = 1'b1;
					wp_n   = ptr_inc(wp_q);
					cnt_n  = cnt_q + CW'(1);
					if (cnt_q == '0) begin
						// idle: start at once
						out_n    = pat_s1;
						hd_dur_n = dur_s1;
						tick_n   = '0;
					end else if (cnt_q == CW'(1)) begin
						// becomes the prefetched second entry
						sec_dur_n = dur_s1;
						sec_pat_n = pat_s1;
					end
				end
			end else if (cnt_q != '0) begin
				tick_n = tick_inc;
				if (tick_inc >= hd_dur_q) begin
					fin_c = 1'b1;
					rp_n  = rp1;
					cnt_n = cnt_q - CW'(1);
					if (cnt_q >= CW'(2)) begin
						out_n    = eff_pat;
						hd_dur_n = eff_dur;
						tick_n   = '0;
						if (cnt_q >= CW'(3)) begin
							// fetch the entry after the new head
							ram_re    = 1'b1;
							sec_ram_n = 1'b1;
						end
					end
				end
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			rp_q      <= '0;
			cnt_q     <= '0;
			tick_q    <= '0;
			out_q     <= '0;
			sec_ram_q <= 1'b0;
		end else begin
			wp_q      <= wp_n;
			rp_q      <= rp_n;
			cnt_q     <= cnt_n;
			tick_q    <= tick_n;
			out_q     <= out_n;
			sec_ram_q <= sec_ram_n;
		end
	end

	// head duration and second entry payload
	always_ff @(posedge clk) begin
		hd_dur_q  <= hd_dur_n;
		sec_dur_q <= sec_dur_n;
		sec_pat_q <= sec_pat_n;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			acc_s2 <= acc_c;
			ovf_s2 <= ovf_c;
			fin_s2 <= fin_c;
			out_s2 <= out_n;
			cnt_s2 <= cnt_n;
		end
	end

	assign fill_ext    = {{FILL_W{1'b0}}, cnt_s2};
	assign done        = valid_s2;
	assign accepted    = acc_s2;
	assign overflow    = ovf_s2;
	assign op_finished = fin_s2;
	assign output_bits = out_s2;
	assign busy_res    = (cnt_s2 != '0);
	assign fill_level  = fill_ext[FILL_W-1:0];

endmodule

@@ hw/rtl/tpq_checker.sv @@
// Port-level checks for the timed output pattern queue, bound to the top level.
module tpq_checker
	import tpq_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic              accepted,
	input logic              overflow,
	input logic              op_finished,
	input logic              busy_res,
	input logic [FILL_W-1:0] fill_level
);

	// a request is never both stored and refused
	a_acc_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(accepted && overflow))
		else $error("accepted and overflow together");

	// an enqueue never completes an operation
	a_acc_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done && accepted |-> !op_finished)
		else $error("op_finished on a stored enqueue");

	// idle means an empty queue
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && !busy_res |-> fill_level == '0)
		else $error("idle with entries held");

	// a full queue always has an operation timing
	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && overflow |-> busy_res)
		else $error("overflow while idle");

	// every request gets its result strobe once through the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("result strobe missing");

endmodule

bind timed_output_pattern_queue tpq_checker u_tpq_checker (.*);
